// ===== sv/bdr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the button debouncer with repeat/hold.
// No dependencies.
package bdr_pkg;

    localparam int RAW_W    = 3;   // raw_levels, hold mask and flag vector width
    localparam int IDX_W    = 2;
    localparam int MODE_W   = 2;
    localparam int PERIOD_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ_PRESS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_HOLD  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MODE_MASK = 2'd2;

    // reset values of the config registers
    localparam logic [PERIOD_W-1:0] RST_REPEAT_PERIOD  = 16'd100;
    localparam logic                RST_PRESSED_LEVEL  = 1'b0;
    localparam logic [RAW_W-1:0]    RST_HOLD_MODE_MASK = 3'd2;

    // config shared by every lane
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                pressed_level;
    } cfg_t;

    // per-lane strobes for the accepted word
    typedef struct packed {
        logic tick;
        logic raw;
        logic clr_press;
        logic clr_hold;
    } lane_ctl_t;

    // lane flags, before and after the accepted word
    typedef struct packed {
        logic press;
        logic hold;
        logic press_next;
        logic hold_next;
    } lane_st_t;

endpackage

// ===== sv/button_debounce_repeat_hold.sv =====
`timescale 1ns / 1ps
// Top level: config registers, one debounce lane per button, merge/output stage.
// Depends on bdr_pkg, bdr_lane, bdr_merge.
//
//  channel  valid      ready      payload
//  input    s_valid    s_ready    s_mode, s_raw_levels, s_button_index
//  result   m_valid    m_ready    m_flag_was_set, m_press_flags, m_hold_flags
//  config   cfg_valid  cfg_ready  cfg_index, cfg_data
//
// One word per cycle while s_ready is high; each result appears in the cycle after its word is
// accepted, set by the single output register behind the lanes.
// s_ready is high whenever the output register is empty or being taken.
// Synchronous active-low reset: buttons start released, flags clear,
// countdowns at 100. cfg_ready is always high.
module button_debounce_repeat_hold #(
    parameter int BUTTONS = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bdr_pkg::MODE_W-1:0]       s_mode,
    input  logic [bdr_pkg::RAW_W-1:0]        s_raw_levels,
    input  logic [bdr_pkg::IDX_W-1:0]        s_button_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_flag_was_set,
    output logic [bdr_pkg::RAW_W-1:0]        m_press_flags,
    output logic [bdr_pkg::RAW_W-1:0]        m_hold_flags,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [bdr_pkg::PERIOD_W-1:0] period_reg;
    logic                         level_reg;
    logic [bdr_pkg::RAW_W-1:0]    mask_reg;
    bdr_pkg::cfg_t                cfg;
    bdr_pkg::lane_ctl_t           ctl   [BUTTONS];
    bdr_pkg::lane_st_t            lanes [BUTTONS];
    logic                         accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= bdr_pkg::RST_REPEAT_PERIOD;
            level_reg  <= bdr_pkg::RST_PRESSED_LEVEL;
            mask_reg   <= bdr_pkg::RST_HOLD_MODE_MASK;
        end else if (cfg_valid) begin
            case (cfg_index)
                bdr_pkg::REG_REPEAT_PERIOD:  period_reg <= cfg_data;
                bdr_pkg::REG_PRESSED_LEVEL:  level_reg  <= cfg_data[0];
                bdr_pkg::REG_HOLD_MODE_MASK: mask_reg   <= cfg_data[bdr_pkg::RAW_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.period        = period_reg;
    assign cfg.pressed_level = level_reg;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
        logic hold_mode;
        // buttons past the field width see level 0 and repeat mode
        if (b < bdr_pkg::RAW_W) begin : g_in
            assign ctl[b].raw = s_raw_levels[b];
            assign hold_mode  = mask_reg[b];
        end else begin : g_out
            assign ctl[b].raw = 1'b0;
            assign hold_mode  = 1'b0;
        end
        assign ctl[b].tick      = accept && (s_mode == bdr_pkg::MODE_TICK);
        assign ctl[b].clr_press = accept && (s_mode == bdr_pkg::MODE_READ_PRESS)
                                  && (32'(s_button_index) == b);
        assign ctl[b].clr_hold  = accept && (s_mode == bdr_pkg::MODE_READ_HOLD)
                                  && (32'(s_button_index) == b);

        bdr_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cfg),
            .hold_mode (hold_mode),
            .ctl       (ctl[b]),
            .st        (lanes[b])
        );
    end

    bdr_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept),
        .unload       (m_ready),
        .mode         (s_mode),
        .idx          (s_button_index),
        .lanes        (lanes),
        .out_valid    (m_valid),
        .flag_was_set (m_flag_was_set),
        .press_flags  (m_press_flags),
        .hold_flags   (m_hold_flags)
    );

endmodule

// ===== sv/bdr_lane.sv =====
`timescale 1ns / 1ps
// One button lane: 3-sample debounce, countdown, press and hold flags.
// Depends on bdr_pkg.
module bdr_lane (
    input  logic              aclk,
    input  logic              aresetn,
    input  bdr_pkg::cfg_t     cfg,
    input  logic              hold_mode,
    input  bdr_pkg::lane_ctl_t ctl,
    output bdr_pkg::lane_st_t st
);

    logic                         old_reg, mid_reg, new_reg, stable_reg;
    logic                         old_next, mid_next, new_next, stable_next;
    logic [bdr_pkg::PERIOD_W-1:0] cd_reg, cd_next, cd_dec;
    logic                         press_reg, press_next, hold_reg, hold_next;
    logic                         pressed;

    always_comb begin
        old_next    = old_reg;
        mid_next    = mid_reg;
        new_next    = new_reg;
        stable_next = stable_reg;
        cd_next     = cd_reg;
        press_next  = press_reg;
        hold_next   = hold_reg;
        pressed     = (ctl.raw == cfg.pressed_level);
        cd_dec      = (cd_reg != '0) ? cd_reg - 1'b1 : cd_reg;
        if (ctl.tick) begin
            old_next = mid_reg;
            mid_next = new_reg;
            new_next = ctl.raw;
            if (mid_reg == new_reg && new_reg == ctl.raw) begin
                if (stable_reg != ctl.raw) begin
                    stable_next = ctl.raw;
                    press_next  = pressed;
                    hold_next   = 1'b0;
                    cd_next     = cfg.period;
                end else if (cd_dec != '0) begin
                    cd_next = cd_dec;
                end else if (hold_mode) begin
                    // expired in hold mode: stays at zero, fires every tick
                    cd_next = cd_dec;
                    if (pressed) begin
                        press_next = 1'b0;
                        hold_next  = 1'b1;
                    end
                end else begin
                    cd_next = cfg.period;
                    if (pressed) begin
                        press_next = 1'b1;
                        hold_next  = 1'b0;
                    end
                end
            end
        end
        if (ctl.clr_press) begin
            press_next = 1'b0;
        end
        if (ctl.clr_hold) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_reg    <= ~bdr_pkg::RST_PRESSED_LEVEL;
            mid_reg    <= ~bdr_pkg::RST_PRESSED_LEVEL;
            new_reg    <= ~bdr_pkg::RST_PRESSED_LEVEL;
            stable_reg <= ~bdr_pkg::RST_PRESSED_LEVEL;
            cd_reg     <= bdr_pkg::RST_REPEAT_PERIOD;
            press_reg  <= 1'b0;
            hold_reg   <= 1'b0;
        end else begin
            old_reg    <= old_next;
            mid_reg    <= mid_next;
            new_reg    <= new_next;
            stable_reg <= stable_next;
            cd_reg     <= cd_next;
            press_reg  <= press_next;
            hold_reg   <= hold_next;
        end
    end

    assign st.press      = press_reg;
    assign st.hold       = hold_reg;
    assign st.press_next = press_next;
    assign st.hold_next  = hold_next;

endmodule

// ===== sv/bdr_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: gathers lane flags and the read result into the output register.
// Depends on bdr_pkg.
module bdr_merge #(
    parameter int BUTTONS = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         unload,
    input  logic [bdr_pkg::MODE_W-1:0]   mode,
    input  logic [bdr_pkg::IDX_W-1:0]    idx,
    input  bdr_pkg::lane_st_t            lanes [BUTTONS],
    output logic                         out_valid,
    output logic                         flag_was_set,
    output logic [bdr_pkg::RAW_W-1:0]    press_flags,
    output logic [bdr_pkg::RAW_W-1:0]    hold_flags
);

    logic                      valid_reg, valid_next;
    logic                      was_reg, was_next;
    logic [bdr_pkg::RAW_W-1:0] press_reg, hold_reg, press_vec, hold_vec;

    // flag vectors carry only the first RAW_W buttons
    for (genvar i = 0; i < bdr_pkg::RAW_W; i++) begin : g_vec
        if (i < BUTTONS) begin : g_lane
            assign press_vec[i] = lanes[i].press_next;
            assign hold_vec[i]  = lanes[i].hold_next;
        end else begin : g_none
            assign press_vec[i] = 1'b0;
            assign hold_vec[i]  = 1'b0;
        end
    end

    always_comb begin
        was_next = 1'b0;
        for (int b = 0; b < BUTTONS; b++) begin
            if (32'(idx) == b) begin
                if (mode == bdr_pkg::MODE_READ_PRESS) begin
                    was_next = lanes[b].press;
                end else if (mode == bdr_pkg::MODE_READ_HOLD) begin
                    was_next = lanes[b].hold;
                end
            end
        end
        valid_next = load ? 1'b1 : (unload ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            was_reg   <= was_next;
            press_reg <= press_vec;
            hold_reg  <= hold_vec;
        end
    end

    assign out_valid    = valid_reg;
    assign flag_was_set = was_reg;
    assign press_flags  = press_reg;
    assign hold_flags   = hold_reg;

endmodule

// ===== sim/button_debounce_repeat_hold_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for button_debounce_repeat_hold: watches all three channels, keeps its own
// debounce/repeat/hold state per button and compares every result word. Depends on bdr_pkg.
module button_debounce_repeat_hold_checker #(
    parameter int BUTTONS = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [bdr_pkg::MODE_W-1:0]       s_mode,
    input  logic [bdr_pkg::RAW_W-1:0]        s_raw_levels,
    input  logic [bdr_pkg::IDX_W-1:0]        s_button_index,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_flag_was_set,
    input  logic [bdr_pkg::RAW_W-1:0]        m_press_flags,
    input  logic [bdr_pkg::RAW_W-1:0]        m_hold_flags,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int unsigned                      fail_count,
    output int unsigned                      pending,
    output int unsigned                      checked
);
    import bdr_pkg::*;

    typedef struct packed {
        logic             was;
        logic [RAW_W-1:0] press;
        logic [RAW_W-1:0] hold;
    } flag_word_t;

    logic [PERIOD_W-1:0] period_q;
    logic                level_q;
    logic [RAW_W-1:0]    hold_mask_q;

    logic                smp_old    [BUTTONS];
    logic                smp_mid    [BUTTONS];
    logic                smp_new    [BUTTONS];
    logic                stable_lvl [BUTTONS];
    logic                press_f    [BUTTONS];
    logic                hold_f     [BUTTONS];
    logic [PERIOD_W-1:0] countdown  [BUTTONS];

    flag_word_t expected_flags [$];
    int unsigned n_fail;
    int unsigned n_checked;

    task automatic reset_buttons();
        period_q    = RST_REPEAT_PERIOD;
        level_q     = RST_PRESSED_LEVEL;
        hold_mask_q = RST_HOLD_MODE_MASK;
        for (int b = 0; b < BUTTONS; b++) begin
            smp_old[b]    = ~RST_PRESSED_LEVEL;
            smp_mid[b]    = ~RST_PRESSED_LEVEL;
            smp_new[b]    = ~RST_PRESSED_LEVEL;
            stable_lvl[b] = ~RST_PRESSED_LEVEL;
            countdown[b]  = RST_REPEAT_PERIOD;
            press_f[b]    = 1'b0;
            hold_f[b]     = 1'b0;
        end
    endtask

    task automatic tick_button(input int b, input logic raw);
        logic pressed;
        smp_old[b] = smp_mid[b];
        smp_mid[b] = smp_new[b];
        smp_new[b] = raw;
        if (smp_old[b] != smp_mid[b] || smp_mid[b] != smp_new[b])
            return;
        pressed = (smp_new[b] == level_q);
        if (stable_lvl[b] != smp_new[b]) begin
            stable_lvl[b] = smp_new[b];
            press_f[b]    = pressed;
            hold_f[b]     = 1'b0;
            countdown[b]  = period_q;
            return;
        end
        // countdown runs on stable released buttons too, saturating at zero
        if (countdown[b] != '0)
            countdown[b] = countdown[b] - 1'b1;
        if (countdown[b] != '0)
            return;
        if (b < RAW_W && hold_mask_q[b]) begin
            // hold fires again on every tick while the count stays at zero
            if (pressed) begin
                press_f[b] = 1'b0;
                hold_f[b]  = 1'b1;
            end
        end else begin
            if (pressed) begin
                press_f[b] = 1'b1;
                hold_f[b]  = 1'b0;
            end
            countdown[b] = period_q;
        end
    endtask

    task automatic debounce_word(input logic [MODE_W-1:0] mode, input logic [RAW_W-1:0] raw,
                                 input logic [IDX_W-1:0] idx, output flag_word_t res);
        res = '0;
        case (mode)
            MODE_TICK: begin
                for (int b = 0; b < BUTTONS; b++)
                    tick_button(b, (b < RAW_W) ? raw[b] : 1'b0);
            end
            MODE_READ_PRESS: begin
                if (idx < BUTTONS) begin
                    res.was      = press_f[idx];
                    press_f[idx] = 1'b0;
                end
            end
            MODE_READ_HOLD: begin
                if (idx < BUTTONS) begin
                    res.was     = hold_f[idx];
                    hold_f[idx] = 1'b0;
                end
            end
            default: ;
        endcase
        for (int b = 0; b < BUTTONS && b < RAW_W; b++) begin
            res.press[b] = press_f[b];
            res.hold[b]  = hold_f[b];
        end
    endtask

    always @(posedge aclk) begin : watch
        flag_word_t want;
        flag_word_t got;
        if (!aresetn) begin
            reset_buttons();
            expected_flags.delete();
            n_fail    = 0;
            n_checked = 0;
        end else begin
            // results first: a word accepted at this edge is answered at a later edge
            if (m_valid && m_ready) begin
                got = {m_flag_was_set, m_press_flags, m_hold_flags};
                if (expected_flags.size() == 0) begin
                    n_fail++;
                    $display("%0t: result word with nothing expected: was=%0d press=%b hold=%b",
                             $time, got.was, got.press, got.hold);
                end else begin
                    want = expected_flags.pop_front();
                    n_checked++;
                    if (got.was !== want.was) begin
                        n_fail++;
                        $display("%0t: flag_was_set expected %0d actual %0d",
                                 $time, want.was, got.was);
                    end
                    if (got.press !== want.press) begin
                        n_fail++;
                        $display("%0t: press_flags expected %b actual %b",
                                 $time, want.press, got.press);
                    end
                    if (got.hold !== want.hold) begin
                        n_fail++;
                        $display("%0t: hold_flags expected %b actual %b",
                                 $time, want.hold, got.hold);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REPEAT_PERIOD:  period_q    = cfg_data[PERIOD_W-1:0];
                    REG_PRESSED_LEVEL:  level_q     = cfg_data[0];
                    REG_HOLD_MODE_MASK: hold_mask_q = cfg_data[RAW_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                debounce_word(s_mode, s_raw_levels, s_button_index, want);
                expected_flags.push_back(want);
            end
        end
        fail_count <= n_fail;
        pending    <= expected_flags.size();
        checked    <= n_checked;
    end

endmodule

// ===== sim/button_debounce_repeat_hold_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for button_debounce_repeat_hold: clock, reset, stimulus and verdict.
// Depends on bdr_pkg, button_debounce_repeat_hold and button_debounce_repeat_hold_checker.
module button_debounce_repeat_hold_tb;
    import bdr_pkg::*;

    localparam int BUTTONS     = 3;
    localparam int PHASE_WORDS = 265;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode         = MODE_TICK;
    logic [RAW_W-1:0]      s_raw_levels   = '0;
    logic [IDX_W-1:0]      s_button_index = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b1;
    logic                  m_flag_was_set;
    logic [RAW_W-1:0]      m_press_flags;
    logic [RAW_W-1:0]      m_hold_flags;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          period_cur;
    int unsigned cycle_cnt = 0;
    int unsigned n_words   = 0;
    int unsigned n_ticks   = 0;
    int unsigned n_reads   = 0;
    int unsigned n_cfg     = 0;

    always #5 aclk = ~aclk;

    button_debounce_repeat_hold #(.BUTTONS(BUTTONS)) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_raw_levels   (s_raw_levels),
        .s_button_index (s_button_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_flag_was_set (m_flag_was_set),
        .m_press_flags  (m_press_flags),
        .m_hold_flags   (m_hold_flags),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    button_debounce_repeat_hold_checker #(.BUTTONS(BUTTONS)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_raw_levels   (s_raw_levels),
        .s_button_index (s_button_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_flag_was_set (m_flag_was_set),
        .m_press_flags  (m_press_flags),
        .m_hold_flags   (m_hold_flags),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [RAW_W-1:0] raw,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_raw_levels   <= raw;
        s_button_index <= idx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        n_words++;
        if (mode == MODE_TICK)
            n_ticks++;
        else if (mode == MODE_READ_PRESS || mode == MODE_READ_HOLD)
            n_reads++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        n_cfg++;
    endtask

    task automatic set_config(input int period, input logic level, input logic [RAW_W-1:0] mask);
        drain();
        write_reg(REG_REPEAT_PERIOD, period[CFG_DATA_W-1:0]);
        write_reg(REG_PRESSED_LEVEL, {{(CFG_DATA_W-1){1'b0}}, level});
        write_reg(REG_HOLD_MODE_MASK, {{(CFG_DATA_W-RAW_W){1'b0}}, mask});
        period_cur = period;
    endtask

    // held raw patterns long enough to debounce and, for periods under 10, expire the countdown,
    // mixed with flag reads, bounces and arbitrary words
    task automatic run_phase(input int words);
        int               sent;
        int               r;
        int               span;
        int               len;
        bit               paused;
        logic [RAW_W-1:0] target;
        sent   = 0;
        paused = 1'b0;
        target = RAW_W'($urandom_range(7));
        while (sent < words) begin
            if (!paused && sent >= words / 2) begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 8) begin
                send_word(MODE_W'($urandom_range(3)), RAW_W'($urandom_range(7)),
                          IDX_W'($urandom_range(3)));
                sent++;
            end else if (r < 32) begin
                send_word($urandom_range(1) ? MODE_READ_HOLD : MODE_READ_PRESS,
                          RAW_W'($urandom_range(7)), IDX_W'($urandom_range(BUTTONS - 1)));
                sent++;
            end else begin
                span = (period_cur < 10) ? period_cur + 6 : 14;
                len  = $urandom_range(span, 1);
                if ($urandom_range(9) < 7)
                    target = RAW_W'($urandom_range(7));
                repeat (len) begin
                    if ($urandom_range(99) < 12)
                        send_word(MODE_TICK, target ^ RAW_W'($urandom_range(7, 1)),
                                  IDX_W'($urandom_range(3)));
                    else
                        send_word(MODE_TICK, target, IDX_W'($urandom_range(3)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: pressed is low, button 1 in hold mode, short period
        set_config(2, 1'b0, 3'b010);
        send_word(MODE_TICK, 3'b111, 2'd0);
        send_word(MODE_UNUSED, 3'b101, 2'd3);
        send_word(MODE_READ_PRESS, 3'b000, 2'd3);
        send_word(MODE_READ_HOLD, 3'b111, 2'd3);
        repeat (3) send_word(MODE_TICK, 3'b000, 2'd0);
        // countdown expires: repeat on buttons 0 and 2 once, hold on button 1 twice
        repeat (3) send_word(MODE_TICK, 3'b000, 2'd1);
        for (int i = 0; i < BUTTONS; i++)
            send_word(MODE_READ_PRESS, 3'b010, i[IDX_W-1:0]);
        for (int i = 0; i < BUTTONS; i++)
            send_word(MODE_READ_HOLD, 3'b101, i[IDX_W-1:0]);
        send_word(MODE_TICK, 3'b101, 2'd2);
        send_word(MODE_TICK, 3'b000, 2'd2);
        // release, then let the countdown run out on released buttons
        repeat (5) send_word(MODE_TICK, 3'b111, 2'd3);
        send_word(MODE_TICK, 3'b010, 2'd0);
        send_word(MODE_READ_PRESS, 3'b000, 2'd1);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(3, 1'b0, 3'b010);
                1: set_config(1, 1'b1, 3'b101);
                2: set_config(0, 1'b0, 3'b111);
                3: set_config(65535, 1'b1, 3'b000);
                4: set_config(2, 1'b1, 3'b011);
                default: set_config(4, 1'b0, 3'b110);
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 76; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 76; end
                default: begin idle_pct = 19; stall_pct <= 19; end
            endcase
            run_phase(PHASE_WORDS);
        end

        drain();
        repeat (4) @(negedge aclk);
        $display("Sent %0d words (%0d ticks, %0d flag reads) over 7 register setups, %0d writes",
                 n_words, n_ticks, n_reads, n_cfg);
        $display("Checked %0d result words, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
